// File: design/msrpg_pkg.sv
// Shared constants and types for the multi-channel stepper ramp pulse generator.
package msrpg_pkg;

  // Channel count is fixed by the 9-bit mask fields
  localparam int CHANNELS    = 9;
  localparam int CH_IDX_BITS = $clog2(CHANNELS);
  localparam int MASK_BITS   = 9;
  localparam int SEL_BITS    = 4;
  localparam int RATE_BITS   = 24;
  localparam int TICK_BITS   = 16;
  localparam int OUT_COUNT_BITS = 32;

  // Defaults for the top-level parameters
  localparam int PHASE_FRACTION_BITS_DEF = 24;
  localparam int COUNT_BITS_DEF          = 32;

  // Register port
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  localparam logic [TICK_BITS-1:0] TIMEOUT_RESET = 16'd100;
  localparam logic [TICK_BITS-1:0] TICKS_MAX     = 16'hFFFF;

  typedef enum logic [1:0] {
    REG_TARGET  = 2'd0,
    REG_START   = 2'd1,
    REG_RAMP    = 2'd2,
    REG_TIMEOUT = 2'd3
  } reg_idx_t;

  // Sequencer request for one channel visit
  typedef struct packed {
    logic                   valid;
    logic                   run;
    logic [CH_IDX_BITS-1:0] chan;
  } chan_ctl_t;

  // Per-channel update result back to the sequencer
  typedef struct packed {
    logic                   valid;
    logic                   step;
    logic [CH_IDX_BITS-1:0] chan;
  } chan_ev_t;

endpackage

// File: design/msrpg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module msrpg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/msrpg_chan.sv
// Channel state memory and the two-stage read-modify-write rate/phase update.
module msrpg_chan
  import msrpg_pkg::*;
#(
  parameter int PHASE_FRACTION_BITS = PHASE_FRACTION_BITS_DEF,
  parameter int COUNT_BITS          = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [RATE_BITS-1:0]  target_increment,
  input  logic [RATE_BITS-1:0]  start_increment,
  input  logic [RATE_BITS-1:0]  ramp_increment,
  input  chan_ctl_t             ctl,
  output chan_ev_t              ev,
  output logic [COUNT_BITS-1:0] ev_count
);
  localparam int PW = PHASE_FRACTION_BITS + 1;
  localparam int W  = RATE_BITS + PW + COUNT_BITS;
  localparam logic [63:0] RESTART_FULL = (64'd999 << PHASE_FRACTION_BITS) / 64'd1000;
  localparam logic [PW-1:0] PHASE_RESTART = RESTART_FULL[PW-1:0];

  logic [W-1:0]          rd_data;
  logic [W-1:0]          wr_data;
  logic                  wr_en;
  logic [CHANNELS-1:0]   entry_valid;

  chan_ctl_t             c1;
  chan_ctl_t             c2;
  logic [RATE_BITS-1:0]  rate2;
  logic [PW-1:0]         phase2;
  logic [COUNT_BITS-1:0] count2;

  logic [RATE_BITS-1:0]  rate1;
  logic [PW-1:0]         phase1;
  logic [COUNT_BITS-1:0] count1;
  logic [RATE_BITS:0]    ramp_sum;
  logic [RATE_BITS-1:0]  rate_next;

  logic [PW-1:0]         phase_sum;
  logic [PW-1:0]         phase_next;
  logic [COUNT_BITS-1:0] count_next;
  logic                  step;

  msrpg_ram #(
    .WIDTH (W),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (c2.chan),
    .wdata (wr_data),
    .re    (ctl.valid),
    .raddr (ctl.chan),
    .rdata (rd_data)
  );

  // Stage 1: unpack entry (never-written entries read as reset state), ramp the rate
  always_comb begin
    if (entry_valid[c1.chan]) begin
      rate1  = rd_data[RATE_BITS-1:0];
      phase1 = rd_data[RATE_BITS +: PW];
      count1 = rd_data[RATE_BITS+PW +: COUNT_BITS];
    end else begin
      rate1  = '0;
      phase1 = PHASE_RESTART;
      count1 = '0;
    end
    ramp_sum = {1'b0, rate1} + {1'b0, ramp_increment};
    if (!c1.run) begin
      rate_next = start_increment;
    end else if (rate1 < target_increment) begin
      rate_next = (ramp_sum > {1'b0, target_increment}) ? target_increment
                                                         : ramp_sum[RATE_BITS-1:0];
    end else begin
      rate_next = rate1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1.valid <= 1'b0;
      c2.valid <= 1'b0;
    end else begin
      c1.valid <= ctl.valid;
      c2.valid <= c1.valid;
    end
    c1.run  <= ctl.run;
    c1.chan <= ctl.chan;
    c2.run  <= c1.run;
    c2.chan <= c1.chan;
    rate2   <= rate_next;
    phase2  <= phase1;
    count2  <= count1;
  end

  // Stage 2: phase accumulate, pulse detect, count, write back
  always_comb begin
    phase_sum = phase2 + PW'(rate2);
    step      = c2.run && phase_sum[PW-1];
    if (!c2.run) begin
      phase_next = PHASE_RESTART;
    end else begin
      phase_next = {1'b0, phase_sum[PW-2:0]} | (phase_sum & {1'b0, {(PW-1){1'b0}}});
    end
    count_next = step ? (count2 + COUNT_BITS'(1)) : count2;
  end

  assign wr_en   = c2.valid;
  assign wr_data = {count_next, phase_next, rate2};

  // Entry valid bits, set on first write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[c2.chan] <= 1'b1;
    end
  end

  assign ev.valid = c2.valid;
  assign ev.step  = step;
  assign ev.chan  = c2.chan;
  assign ev_count = count_next;

  // A write-back always follows its read through the c1 and c2 stage registers
  a_wb_after_read: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> $past(ctl.valid, 2))
    else $error("write-back without matching read");

  // Only running channels pulse
  a_step_needs_run: assert property (@(posedge clk) disable iff (rst)
    (wr_en && step) |-> c2.run)
    else $error("step on a stopped channel");

  // A stopped channel writes the restart phase
  a_stop_restart: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !c2.run) |-> (phase_next == PHASE_RESTART && !step))
    else $error("stopped channel not reloaded");

endmodule

// File: design/multi_stepper_ramp_pulse_generator.sv
// Top level: register port, stale watchdog, channel sequencer and result register.
// Each accepted tick sweeps the channel state memory, one entry per cycle through
// a two-stage read-modify-write pipeline, then drains it and loads the result register.
// Only one tick is in flight at a time; tick_ready is high only in the idle state.
// A new tick is taken while the previous result still waits in the output register.
// Reset (synchronous, active high) clears control state, registers to their
// defaults and the memory entry valid bits; unwritten entries read as reset state.
module multi_stepper_ramp_pulse_generator
  import msrpg_pkg::*;
#(
  parameter int PHASE_FRACTION_BITS = PHASE_FRACTION_BITS_DEF,
  parameter int COUNT_BITS          = COUNT_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // register port
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_BITS-1:0]      paddr,
  input  logic [DATA_BITS-1:0]      pwdata,
  output logic [DATA_BITS-1:0]      prdata,
  output logic                      pready,
  // tick channel
  input  logic                      tick_valid,
  output logic                      tick_ready,
  input  logic [MASK_BITS-1:0]      run_mask,
  input  logic [MASK_BITS-1:0]      dir_open_mask,
  input  logic                      sensor_fresh,
  input  logic                      stale_ack,
  input  logic [SEL_BITS-1:0]       count_select,
  // result channel
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic [MASK_BITS-1:0]      step_mask,
  output logic [MASK_BITS-1:0]      dir_level_mask,
  output logic                      stale_now,
  output logic                      stale_seen,
  output logic [OUT_COUNT_BITS-1:0] selected_count
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t                   state;
  logic [RATE_BITS-1:0]     target_increment;
  logic [RATE_BITS-1:0]     start_increment;
  logic [RATE_BITS-1:0]     ramp_increment;
  logic [TICK_BITS-1:0]     timeout_ticks;
  logic [TICK_BITS-1:0]     ticks_since_fresh;
  logic                     stale_sticky;

  logic [TICK_BITS-1:0]     ticks_next;
  logic                     stale_next;
  logic                     accept;
  logic                     cfg_write;
  reg_idx_t                 cfg_idx;

  logic [CH_IDX_BITS-1:0]   idx;
  logic [MASK_BITS-1:0]     run_lat;
  logic [MASK_BITS-1:0]     dir_lat;
  logic [SEL_BITS-1:0]      sel_lat;
  logic                     stale_lat;
  logic                     seen_lat;
  logic [MASK_BITS-1:0]     step_acc;
  logic [OUT_COUNT_BITS-1:0] count_lat;

  chan_ctl_t                ctl;
  chan_ev_t                 ev;
  logic [COUNT_BITS-1:0]    ev_count;

  localparam logic [CH_IDX_BITS-1:0] LAST_CH = CH_IDX_BITS'(CHANNELS - 1);

  // Register port
  assign pready    = 1'b1;
  assign cfg_idx   = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_increment <= '0;
      start_increment  <= '0;
      ramp_increment   <= '0;
      timeout_ticks    <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_TARGET:  target_increment <= pwdata[RATE_BITS-1:0];
        REG_START:   start_increment  <= pwdata[RATE_BITS-1:0];
        REG_RAMP:    ramp_increment   <= pwdata[RATE_BITS-1:0];
        REG_TIMEOUT: timeout_ticks    <= pwdata[TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TARGET:  prdata = DATA_BITS'(target_increment);
      REG_START:   prdata = DATA_BITS'(start_increment);
      REG_RAMP:    prdata = DATA_BITS'(ramp_increment);
      REG_TIMEOUT: prdata = DATA_BITS'(timeout_ticks);
      default:     prdata = '0;
    endcase
  end

  // Stale watchdog, evaluated at tick accept
  assign tick_ready = (state == S_IDLE);
  assign accept     = tick_valid && tick_ready;

  always_comb begin
    if (sensor_fresh) begin
      ticks_next = '0;
    end else if (ticks_since_fresh != TICKS_MAX) begin
      ticks_next = ticks_since_fresh + TICK_BITS'(1);
    end else begin
      ticks_next = ticks_since_fresh;
    end
    stale_next = (ticks_next > timeout_ticks);
  end

  // Channel visit request
  assign ctl.valid = (state == S_RUN);
  assign ctl.run   = run_lat[idx] && !stale_lat;
  assign ctl.chan  = idx;

  msrpg_chan #(
    .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS),
    .COUNT_BITS          (COUNT_BITS)
  ) u_chan (
    .clk              (clk),
    .rst              (rst),
    .target_increment (target_increment),
    .start_increment  (start_increment),
    .ramp_increment   (ramp_increment),
    .ctl              (ctl),
    .ev               (ev),
    .ev_count         (ev_count)
  );

  // Sequencer, watchdog state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      result_valid      <= 1'b0;
      ticks_since_fresh <= '0;
      stale_sticky      <= 1'b0;
      idx               <= '0;
    end else begin
      // in S_DONE the result register load below owns result_valid
      if (result_valid && result_ready && state != S_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            ticks_since_fresh <= ticks_next;
            stale_sticky      <= (stale_sticky || stale_next) && !stale_ack;
            idx               <= '0;
            state             <= S_RUN;
          end
        end
        S_RUN: begin
          if (idx == LAST_CH) begin
            state <= S_DRAIN;
          end else begin
            idx <= idx + CH_IDX_BITS'(1);
          end
        end
        S_DRAIN: begin
          if (ev.valid && ev.chan == LAST_CH) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid   <= 1'b1;
            step_mask      <= step_acc;
            dir_level_mask <= dir_lat;
            stale_now      <= stale_lat;
            stale_seen     <= seen_lat;
            selected_count <= count_lat;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Per-tick payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      run_lat   <= run_mask;
      dir_lat   <= dir_open_mask;
      sel_lat   <= count_select;
      stale_lat <= stale_next;
      seen_lat  <= stale_sticky || stale_next;
      step_acc  <= '0;
      count_lat <= '0;
    end else if (ev.valid) begin
      step_acc[ev.chan] <= ev.step;
      if (SEL_BITS'(ev.chan) == sel_lat) begin
        count_lat <= OUT_COUNT_BITS'(ev_count);
      end
    end
  end

  // One tick at a time
  a_one_tick: assert property (@(posedge clk) disable iff (rst)
    accept |=> !tick_ready)
    else $error("tick accepted while busy");

  // A stale tick never pulses
  a_stale_quiet: assert property (@(posedge clk) disable iff (rst)
    (result_valid && stale_now) |-> (step_mask == '0 && stale_seen))
    else $error("stale tick produced steps or lost sticky flag");

  // Channel updates only come back while a tick is in flight
  a_ev_in_tick: assert property (@(posedge clk) disable iff (rst)
    ev.valid |-> (state == S_RUN || state == S_DRAIN))
    else $error("channel update outside a tick");

  // Channel sweep always reaches the last channel before finishing
  a_sweep_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN && ev.valid && ev.chan == LAST_CH) |=> (state == S_DONE))
    else $error("sweep did not complete");

endmodule
